FILE: hdl/ats_pkg.sv
`default_nettype none

package ats_pkg;

    // Series length limits and the constant pi/2 in Q1.29
    localparam int TERMS_DEFAULT = 32;
    localparam int TABLE_LEN     = 64;
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;

    // Widths of the datapath
    localparam int XW    = 32;   // argument
    localparam int AW    = 31;   // angle
    localparam int MW    = 31;   // Q0.30 magnitude, up to 2^30
    localparam int QW    = 30;   // reciprocal quotient bits
    localparam int REMW  = 47;   // dividend 2^46 + mag/2
    localparam int SUMW  = 34;   // signed running sum
    localparam int ONE_SHIFT = 16;  // |x| <= 1.0 in Q16.16

    // Control that travels with each transaction down the chain
    typedef struct packed {
        logic valid;
        logic neg;
        logic big;
    } ctl_t;

    // Q0.30 product, rounded to nearest with halves up
    function automatic logic [MW-1:0] mul_q30(input logic [MW-1:0] a,
                                              input logic [MW-1:0] b);
        logic [2*MW-1:0] prod;
        prod = (2*MW)'(a) * (2*MW)'(b) + ((2*MW)'(1) << 29);
        return prod[MW+29:30];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ats_div_cell.sv
`default_nettype none

// One quotient bit of the restoring divide 2^46 / |x|
module ats_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ats_pkg::ctl_t               in_ctl,
    input  wire logic [ats_pkg::XW-1:0]      in_mag,
    input  wire logic [ats_pkg::REMW-1:0]    in_rem,
    input  wire logic [ats_pkg::QW-1:0]      in_quo,
    output ats_pkg::ctl_t                    out_ctl,
    output logic [ats_pkg::XW-1:0]           out_mag,
    output logic [ats_pkg::REMW-1:0]         out_rem,
    output logic [ats_pkg::QW-1:0]           out_quo
);

    localparam int TW = ats_pkg::XW + ats_pkg::QW;

    logic [TW-1:0]               trial;
    logic                        take;
    ats_pkg::ctl_t               ctl_reg;
    logic [ats_pkg::XW-1:0]      mag_reg;
    logic [ats_pkg::REMW-1:0]    rem_reg;
    logic [ats_pkg::REMW-1:0]    rem_next;
    logic [ats_pkg::QW-1:0]      quo_reg;
    logic [ats_pkg::QW-1:0]      quo_next;

    // Compare the remainder against the shifted divisor
    always_comb
    begin
        trial    = TW'(in_mag) << SHIFT;
        take     = TW'(in_rem) >= trial;
        rem_next = take ? ats_pkg::REMW'(TW'(in_rem) - trial) : in_rem;
        quo_next = in_quo | (take ? (ats_pkg::QW'(1) << SHIFT) : '0);
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        mag_reg <= in_mag;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign out_ctl = ctl_reg;
    assign out_mag = mag_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/ats_term_cell.sv
`default_nettype none

// One series term: add or subtract p/(2i+1), then raise p by m^2
module ats_term_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ats_pkg::ctl_t                 in_ctl,
    input  wire logic [ats_pkg::MW-1:0]        in_m2,
    input  wire logic [ats_pkg::MW-1:0]        in_pow,
    input  wire logic signed [ats_pkg::SUMW-1:0] in_sum,
    output ats_pkg::ctl_t                      out_ctl,
    output logic [ats_pkg::MW-1:0]             out_m2,
    output logic [ats_pkg::MW-1:0]             out_pow,
    output logic signed [ats_pkg::SUMW-1:0]    out_sum
);

    localparam longint unsigned K = 2 * INDEX + 1;
    localparam logic [ats_pkg::MW-1:0] RECIP =
        ats_pkg::MW'(((64'd1 << 30) + K / 2) / K);

    logic [ats_pkg::MW-1:0]             term;
    ats_pkg::ctl_t                      ctl_reg;
    logic [ats_pkg::MW-1:0]             m2_reg;
    logic [ats_pkg::MW-1:0]             pow_reg;
    logic [ats_pkg::MW-1:0]             pow_next;
    logic signed [ats_pkg::SUMW-1:0]    sum_reg;
    logic signed [ats_pkg::SUMW-1:0]    sum_next;

    // Scale the power by the reciprocal and fold it into the sum
    always_comb
    begin
        term     = ats_pkg::mul_q30(in_pow, RECIP);
        pow_next = ats_pkg::mul_q30(in_pow, in_m2);
        if ((INDEX % 2) == 0)
        begin
            sum_next = in_sum + $signed({{(ats_pkg::SUMW-ats_pkg::MW){1'b0}}, term});
        end
        else
        begin
            sum_next = in_sum - $signed({{(ats_pkg::SUMW-ats_pkg::MW){1'b0}}, term});
        end
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        m2_reg  <= in_m2;
        pow_reg <= pow_next;
        sum_reg <= sum_next;
    end

    assign out_ctl = ctl_reg;
    assign out_m2  = m2_reg;
    assign out_pow = pow_reg;
    assign out_sum = sum_reg;

endmodule

`default_nettype wire

FILE: hdl/arctangent_series_unit.sv
// Channel  | Ports                  | Handshake
// ---------+------------------------+----------------------------------
// command  | start, x_value, busy   | taken when start & !busy
// result   | done, angle            | one-cycle strobe, no backpressure
//
// A new transaction is taken every cycle; busy stays low.
// Stages: one input register, 30 divider cells for 1/|x|, one m^2 multiply,
// one cell per series term (TERMS' = TERMS limited to 64), one output
// register.
// Reset clears the valid bits of the chain; data registers are not reset.
// The receiver cannot stall, so a result is shown once and then dropped.
`default_nettype none

module arctangent_series_unit #(
    parameter int TERMS = ats_pkg::TERMS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [ats_pkg::XW-1:0]   x_value,
    output logic                                 done,
    output logic signed [ats_pkg::AW-1:0]        angle
);

    localparam int NT = (TERMS > ats_pkg::TABLE_LEN) ? ats_pkg::TABLE_LEN : TERMS;
    localparam int ND = ats_pkg::QW;
    localparam int MW = ats_pkg::MW;
    localparam int SW = ats_pkg::SUMW;

    // Input stage
    logic [ats_pkg::XW-1:0]    mag_in;
    ats_pkg::ctl_t             ctl_in;
    ats_pkg::ctl_t             ctl0_reg;
    logic [ats_pkg::XW-1:0]    mag0_reg;
    logic [ats_pkg::REMW-1:0]  rem0;

    assign busy = 1'b0;

    // Take the magnitude and sort the transaction by range
    always_comb
    begin
        mag_in       = x_value[ats_pkg::XW-1] ? (~x_value + 1'b1) : x_value;
        ctl_in.valid = start & ~busy;
        ctl_in.neg   = x_value[ats_pkg::XW-1];
        ctl_in.big   = mag_in > (ats_pkg::XW'(1) << ats_pkg::ONE_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        mag0_reg <= mag_in;
    end

    assign rem0 = (ats_pkg::REMW'(1) << 46) + ats_pkg::REMW'(mag0_reg >> 1);

    // Divider chain, quotient bit 29 first
    ats_pkg::ctl_t             dctl [ND+1];
    logic [ats_pkg::XW-1:0]    dmag [ND+1];
    logic [ats_pkg::REMW-1:0]  drem [ND+1];
    logic [ats_pkg::QW-1:0]    dquo [ND+1];

    assign dctl[0] = ctl0_reg;
    assign dmag[0] = mag0_reg;
    assign drem[0] = rem0;
    assign dquo[0] = '0;

    for (genvar g = 0; g < ND; g++)
    begin : g_div
        ats_div_cell #(
            .SHIFT (ND - 1 - g)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (dctl[g]),
            .in_mag  (dmag[g]),
            .in_rem  (drem[g]),
            .in_quo  (dquo[g]),
            .out_ctl (dctl[g+1]),
            .out_mag (dmag[g+1]),
            .out_rem (drem[g+1]),
            .out_quo (dquo[g+1])
        );
    end

    // Pick the series argument and square it
    logic [MW-1:0]   m_sel;
    ats_pkg::ctl_t   ctl1_reg;
    logic [MW-1:0]   m1_reg;
    logic [MW-1:0]   m2_reg;

    assign m_sel = dctl[ND].big ? MW'(dquo[ND]) : MW'(dmag[ND] << 14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= dctl[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m_sel;
        m2_reg <= ats_pkg::mul_q30(m_sel, m_sel);
    end

    // Series chain
    ats_pkg::ctl_t         tctl [NT+1];
    logic [MW-1:0]         tm2  [NT+1];
    logic [MW-1:0]         tpow [NT+1];
    logic signed [SW-1:0]  tsum [NT+1];

    assign tctl[0] = ctl1_reg;
    assign tm2[0]  = m2_reg;
    assign tpow[0] = m1_reg;
    assign tsum[0] = '0;

    for (genvar g = 0; g < NT; g++)
    begin : g_term
        ats_term_cell #(
            .INDEX (g)
        ) u_term (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (tctl[g]),
            .in_m2   (tm2[g]),
            .in_pow  (tpow[g]),
            .in_sum  (tsum[g]),
            .out_ctl (tctl[g+1]),
            .out_m2  (tm2[g+1]),
            .out_pow (tpow[g+1]),
            .out_sum (tsum[g+1])
        );
    end

    // Clamp, halve, reflect and sign the sum
    logic signed [SW-1:0]          s_clamp;
    logic signed [SW-1:0]          half;
    logic signed [SW-1:0]          refl;
    logic signed [SW-1:0]          signed_val;
    logic signed [ats_pkg::AW-1:0] angle_next;
    logic                          done_reg;
    logic signed [ats_pkg::AW-1:0] angle_reg;

    always_comb
    begin
        s_clamp    = tsum[NT][SW-1] ? '0 : tsum[NT];
        half       = (s_clamp + SW'(1)) >>> 1;
        refl       = tctl[NT].big ? (ats_pkg::HALF_PI_Q29 - half) : half;
        signed_val = tctl[NT].neg ? -refl : refl;
        if (signed_val > SW'(1073741823))
        begin
            angle_next = {1'b0, {(ats_pkg::AW-1){1'b1}}};
        end
        else if (signed_val < -SW'(1073741824))
        begin
            angle_next = {1'b1, {(ats_pkg::AW-1){1'b0}}};
        end
        else
        begin
            angle_next = signed_val[ats_pkg::AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tctl[NT].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

FILE: hdl/ats_checker.sv
`default_nettype none

module ats_checker #(
    parameter int TERMS = ats_pkg::TERMS_DEFAULT
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic signed [ats_pkg::XW-1:0] x_value,
    input wire logic                          done,
    input wire logic signed [ats_pkg::AW-1:0] angle
);

    localparam int NT  = (TERMS > ats_pkg::TABLE_LEN) ? ats_pkg::TABLE_LEN : TERMS;
    localparam int LAT = NT + 33;

    // Every taken transaction produces a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("result missing after fixed latency");

    // No result without a transaction behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a transaction");

    // Zero in gives zero out
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && x_value == 0 |-> ##LAT angle == 0)
        else $error("nonzero angle for zero argument");

    // Non-negative argument gives non-negative angle
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !x_value[ats_pkg::XW-1] |-> ##LAT !angle[ats_pkg::AW-1])
        else $error("negative angle for non-negative argument");

endmodule

bind arctangent_series_unit ats_checker #(.TERMS(TERMS)) u_ats_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int NTERMS  = (ats_pkg::TERMS_DEFAULT > ats_pkg::TABLE_LEN) ?
                             ats_pkg::TABLE_LEN : ats_pkg::TERMS_DEFAULT;
    localparam int LATENCY = NTERMS + 33;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [ats_pkg::XW-1:0] x_value;
    logic                          done;
    logic signed [ats_pkg::AW-1:0] angle;

    logic signed [ats_pkg::XW-1:0] arg_queue[$];
    logic signed [ats_pkg::AW-1:0] angle_queue[$];
    int                            mismatches;
    int                            gap_left;
    bit                            feeding_done;

    arctangent_series_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .x_value (x_value),
        .done    (done),
        .angle   (angle)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Q0.30 product, rounded to nearest with halves up
    function automatic logic [63:0] q30_product(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    // Sum the alternating arctangent series on a Q0.30 magnitude
    function automatic logic signed [63:0] atan_series_sum(input logic [63:0] m);
        logic [63:0]        m2;
        logic [63:0]        pw;
        logic [63:0]        rcp;
        logic signed [63:0] acc;
        m2  = q30_product(m, m);
        pw  = m;
        acc = 0;
        for (int i = 0; i < NTERMS; i++)
        begin
            rcp = (64'd1073741824 + i) / (2 * i + 1);
            if (i % 2 == 0)
                acc = acc + $signed(q30_product(pw, rcp));
            else
                acc = acc - $signed(q30_product(pw, rcp));
            pw = q30_product(pw, m2);
        end
        if (acc < 0)
            acc = 0;
        return acc;
    endfunction

    // Predict the Q1.29 angle for one argument
    function automatic logic signed [ats_pkg::AW-1:0] predict_angle(
        input logic signed [ats_pkg::XW-1:0] x);
        logic signed [63:0] xs;
        logic [63:0]        mag;
        logic [63:0]        m;
        logic signed [63:0] r;
        xs  = x;
        mag = (xs < 0) ? -xs : xs;
        if (mag == 0)
            r = 0;
        else if (mag <= 64'd65536)
            r = (atan_series_sum(mag << 14) + 1) >>> 1;
        else
        begin
            m = ((64'd1 << 46) + mag / 2) / mag;
            r = 64'sd843314857 - ((atan_series_sum(m) + 1) >>> 1);
        end
        if (xs < 0)
            r = -r;
        if (r > 64'sd1073741823)
            r = 64'sd1073741823;
        if (r < -64'sd1073741824)
            r = -64'sd1073741824;
        return r[ats_pkg::AW-1:0];
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Fill the argument queue: directed edges, then random arguments
    initial
    begin
        logic signed [ats_pkg::XW-1:0] v;
        arg_queue = '{32'sd0, 32'sd1, -32'sd1, 32'sd65536, -32'sd65536, 32'sd65535,
                      32'sd65537, -32'sd65537, 32'sd32768, 32'sd131072,
                      32'h7FFFFFFF, 32'h80000000, 32'h80000001, -32'sd2,
                      32'h55555555, 32'hAAAAAAAA, 32'sd3, 32'sd100000, -32'sd7};
        for (int n = 0; n < 400; n++)
        begin
            case ($urandom_range(0, 3))
                0: v = $signed($urandom_range(0, 65536)) * ($urandom_range(0, 1) ? 1 : -1);
                1: v = $urandom;
                2: v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                default: v = $signed($urandom_range(0, 4)) + 65534
                             - ($urandom_range(0, 1) ? 0 : 131068);
            endcase
            arg_queue.push_back(v);
        end
    end

    // Reset once
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Drive arguments from the queue, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            x_value      <= '0;
            gap_left     <= 0;
            feeding_done <= 1'b0;
        end
        else if (start && busy)
        begin
            // hold the transaction
        end
        else
        begin
            if (start)
                angle_queue.push_back(predict_angle(x_value));
            if (gap_left > 0 || arg_queue.size() == 0)
            begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else
                    feeding_done <= 1'b1;
            end
            else
            begin
                start    <= 1'b1;
                x_value  <= arg_queue.pop_front();
                gap_left <= pick_gap();
            end
        end
    end

    // Check each result against the oldest prediction
    always @(posedge clk)
    begin
        logic signed [ats_pkg::AW-1:0] want;
        if (rst_n && done)
        begin
            if (angle_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result angle=%0d", angle);
            end
            else
            begin
                want = angle_queue.pop_front();
                if (angle !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("angle mismatch: expected %0d got %0d", want, angle);
                end
            end
        end
    end

    // Wait for the drain, then report
    initial
    begin
        mismatches = 0;
        wait (feeding_done === 1'b1);
        wait (angle_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && angle_queue.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Timeout
    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ats_pkg.sv
hdl/ats_div_cell.sv
hdl/ats_term_cell.sv
hdl/arctangent_series_unit.sv
hdl/ats_checker.sv
tb/tb.sv
